@@ rtl/amgt_pkg.sv @@
// Shared constants and types for the adjacency-matrix graph traversal block.
`timescale 1ns / 1ps
package amgt_pkg;

	localparam int VERTEX_COUNT = 8;
	localparam int VIW          = $clog2(VERTEX_COUNT);      // vertex index width
	localparam int CW           = $clog2(VERTEX_COUNT + 1);  // counter width, holds VERTEX_COUNT

	localparam logic ACT_INSERT   = 1'b0;
	localparam logic ACT_TRAVERSE = 1'b1;

	localparam logic KIND_BFS = 1'b0;
	localparam logic KIND_DFS = 1'b1;

	typedef struct packed {
		logic [VIW-1:0] vtx;
		logic [CW-1:0]  next;
	} frame_t;

endpackage

@@ rtl/adjacency_matrix_graph_traversal.sv @@
// Top level: adjacency bit matrix with BFS then DFS traversal under one scan sequencer.
//
//  channel | dir | tdata (low bit up)              | tuser       | tlast
//  s_*     | in  | vertex_a[2:0], vertex_b[5:3]    | action      | -
//  m_*     | out | vertex[2:0]                     | order_kind  | last
//
// During a traverse the sequencer tests one adjacency bit per cycle in the BFS and DFS scans, and
// a whole adjacency row per step in the start search.
// s_tready is high only while the sequencer is idle.
// One word is held back so the final one can carry last; a stalled m_* holds the sequencer.
// Reset clears the matrix and all control state.
`timescale 1ns / 1ps
module adjacency_matrix_graph_traversal
	import amgt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // vertex_a[2:0], vertex_b[5:3], zeros
	input  logic       s_tuser,   // action
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // vertex[2:0], zeros
	output logic       m_tuser,   // order_kind
	output logic       m_tlast
);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_FIND     = 3'd1;
	localparam logic [2:0] ST_BFS_POP  = 3'd2;
	localparam logic [2:0] ST_BFS_SCAN = 3'd3;
	localparam logic [2:0] ST_DFS_TOP  = 3'd4;
	localparam logic [2:0] ST_DFS_SCAN = 3'd5;
	localparam logic [2:0] ST_DONE     = 3'd6;

	logic [2:0]              state_q;
	logic [VERTEX_COUNT-1:0] adj_q [VERTEX_COUNT];
	logic [VERTEX_COUNT-1:0] visited_q;
	logic [VIW-1:0]          queue_q [VERTEX_COUNT];
	frame_t                  stack_q [VERTEX_COUNT];
	logic [CW-1:0]           head_q, tail_q, depth_q, idx_q;
	logic [VIW-1:0]          cur_q, start_q;

	logic [VIW-1:0] pend_vertex_q;
	logic           pend_kind_q, pend_valid_q;
	logic [VIW-1:0] out_vertex_q;
	logic           out_kind_q, out_last_q, m_tvalid_q;

	logic [2:0]     in_a, in_b;
	logic           out_free, row_any, find_end, scan_hit, dfs_hit, idx_end, q_more;
	logic [VIW-1:0] idx_v, start_sel, top_idx;
	frame_t         top_f;
	logic           emit_en, emit_kind;
	logic [VIW-1:0] emit_vtx;

	always_comb begin
		in_a      = s_tdata[2:0];
		in_b      = s_tdata[5:3];
		out_free  = !m_tvalid_q || m_tready;
		idx_v     = idx_q[VIW-1:0];
		idx_end   = (idx_q == CW'(VERTEX_COUNT));
		row_any   = |adj_q[idx_v];
		find_end  = row_any || (idx_q == CW'(VERTEX_COUNT - 1));
		start_sel = row_any ? idx_v : '0;
		scan_hit  = adj_q[cur_q][idx_v] && !visited_q[idx_v];
		top_idx   = VIW'(depth_q - 1'b1);
		top_f     = stack_q[top_idx];
		dfs_hit   = adj_q[top_f.vtx][idx_v] && !visited_q[idx_v];
		q_more    = (head_q < tail_q);
		emit_en   = out_free && ((state_q == ST_BFS_POP) ||
			(state_q == ST_DFS_SCAN && !idx_end && dfs_hit &&
			 depth_q < CW'(VERTEX_COUNT)));
		if (state_q == ST_BFS_POP) begin
			emit_vtx  = q_more ? queue_q[head_q[VIW-1:0]] : start_q;
			emit_kind = q_more ? KIND_BFS : KIND_DFS;
		end else begin
			emit_vtx  = idx_v;
			emit_kind = KIND_DFS;
		end
	end

	// adjacency matrix and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			head_q       <= '0;
			tail_q       <= '0;
			depth_q      <= '0;
			idx_q        <= '0;
			m_tvalid_q   <= 1'b0;
			pend_valid_q <= 1'b0;
			for (int r = 0; r < VERTEX_COUNT; r++) begin
				adj_q[r] <= '0;
			end
		end else begin
			// previous word goes out once the next one is known, the final one at done
			if ((emit_en && pend_valid_q) || (state_q == ST_DONE && out_free)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						if (s_tuser == ACT_TRAVERSE) begin
							idx_q   <= '0;
							state_q <= ST_FIND;
						end else if (CW'(in_a) < CW'(VERTEX_COUNT) &&
							CW'(in_b) < CW'(VERTEX_COUNT)) begin
							adj_q[VIW'(in_a)][VIW'(in_b)] <= 1'b1;
							adj_q[VIW'(in_b)][VIW'(in_a)] <= 1'b1;
						end
					end
				end
				ST_FIND: begin
					if (find_end) begin
						head_q  <= '0;
						tail_q  <= CW'(1);
						state_q <= ST_BFS_POP;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_BFS_POP: begin
					if (out_free) begin
						if (q_more) begin
							head_q  <= head_q + 1'b1;
							idx_q   <= '0;
							state_q <= ST_BFS_SCAN;
						end else begin
							depth_q <= CW'(1);
							state_q <= ST_DFS_TOP;
						end
					end
				end
				ST_BFS_SCAN: begin
					if (scan_hit && tail_q < CW'(VERTEX_COUNT)) begin
						tail_q <= tail_q + 1'b1;
					end
					if (idx_q == CW'(VERTEX_COUNT - 1)) begin
						state_q <= ST_BFS_POP;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_DFS_TOP: begin
					if (depth_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						idx_q   <= top_f.next;
						state_q <= ST_DFS_SCAN;
					end
				end
				ST_DFS_SCAN: begin
					if (idx_end) begin
						depth_q <= depth_q - 1'b1;
						state_q <= ST_DFS_TOP;
					end else if (dfs_hit) begin
						if (out_free) begin
							if (depth_q < CW'(VERTEX_COUNT)) begin
								depth_q <= depth_q + 1'b1;
							end else begin
								depth_q <= depth_q - 1'b1;
							end
							state_q <= ST_DFS_TOP;
						end
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (emit_en) begin
				pend_valid_q <= 1'b1;
			end
		end
	end

	// traversal payload: visited set, queue, stack and output words
	always_ff @(posedge clk) begin
		case (state_q)
			ST_FIND: begin
				if (find_end) begin
					start_q    <= start_sel;
					visited_q  <= VERTEX_COUNT'(1) << start_sel;
					queue_q[0] <= start_sel;
				end
			end
			ST_BFS_POP: begin
				if (out_free) begin
					if (q_more) begin
						cur_q <= queue_q[head_q[VIW-1:0]];
					end else begin
						visited_q  <= VERTEX_COUNT'(1) << start_q;
						stack_q[0] <= '{vtx: start_q, next: '0};
					end
				end
			end
			ST_BFS_SCAN: begin
				if (scan_hit && tail_q < CW'(VERTEX_COUNT)) begin
					visited_q[idx_v]              <= 1'b1;
					queue_q[tail_q[VIW-1:0]]      <= idx_v;
				end
			end
			ST_DFS_SCAN: begin
				if (emit_en) begin
					stack_q[top_idx].next       <= idx_q + 1'b1;
					visited_q[idx_v]            <= 1'b1;
					stack_q[depth_q[VIW-1:0]]   <= '{vtx: idx_v, next: '0};
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_vertex_q <= pend_vertex_q;
					out_kind_q   <= pend_kind_q;
					out_last_q   <= 1'b1;
				end
			end
			default: ;
		endcase
		if (emit_en) begin
			pend_vertex_q <= emit_vtx;
			pend_kind_q   <= emit_kind;
			if (pend_valid_q) begin
				out_vertex_q <= pend_vertex_q;
				out_kind_q   <= pend_kind_q;
				out_last_q   <= 1'b0;
			end
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(8 - VIW){1'b0}}, out_vertex_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

endmodule

@@ rtl/amgt_checker.sv @@
// Port-level checker for the graph traversal block, bound to the top level.
`timescale 1ns / 1ps
module amgt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic [7:0] s_tdata,
	input logic       s_tuser,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tuser,
	input logic       m_tlast
);

	// a stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
		$stable(m_tlast))
		else $error("output word changed while stalled");

	// a traversal keeps the input side closed
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser |=> !s_tready)
		else $error("input accepted during traversal");

	// a word that is not the final one means the run is still going
	a_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("idle with a traversal word pending");

	// nothing follows the final word until a new traversal
	a_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> !m_tvalid)
		else $error("word after final word");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7:3] == 5'd0)
		else $error("nonzero padding in output word");

endmodule

bind adjacency_matrix_graph_traversal amgt_checker u_amgt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

@@ tb/adjacency_matrix_graph_traversal_tb.sv @@
// Testbench for the adjacency-matrix graph traversal block: streamed edges, BFS/DFS order checks.
`timescale 1ns / 1ps
module adjacency_matrix_graph_traversal_tb;
	import amgt_pkg::*;

	typedef struct packed {
		logic           act;
		logic [VIW-1:0] va;
		logic [VIW-1:0] vb;
	} graph_cmd_t;

	typedef struct packed {
		logic [VIW-1:0] vertex;
		logic           kind;
		logic           last;
	} visit_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;   // vertex_a[2:0], vertex_b[5:3], zeros
	logic       s_tuser = 1'b0;    // action
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;           // vertex[2:0], zeros
	logic       m_tuser;           // order_kind
	logic       m_tlast;

	graph_cmd_t             pending_cmds [$];
	visit_t                 expected_visits [$];
	logic [VERTEX_COUNT-1:0] adj_rows [VERTEX_COUNT];
	logic                   word_taken = 1'b0;
	int                     fail_count = 0;
	int                     burst_left = 4;
	int                     gap_left = 0;
	logic [15:0]            ready_pattern = 16'hffff;
	int                     pattern_age = 0;

	adjacency_matrix_graph_traversal u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// BFS order then DFS preorder from the lowest vertex with an edge; one visited set per pass
	function automatic void plan_traversal();
		logic [VERTEX_COUNT-1:0] seen_set;
		int                      fifo [VERTEX_COUNT];
		int                      stk_v [VERTEX_COUNT];
		int                      stk_next [VERTEX_COUNT];
		int                      head, tail, depth, start, cur, nxt;
		visit_t                  run [$];
		visit_t                  vis;
		start = 0;
		for (int i = VERTEX_COUNT - 1; i >= 0; i--)
			if (adj_rows[i] != '0) start = i;

		seen_set = '0;
		seen_set[start] = 1'b1;
		head = 0;
		tail = 1;
		fifo[0] = start;
		while (head < tail) begin
			cur = fifo[head];
			head++;
			run.push_back('{vertex: cur[VIW-1:0], kind: KIND_BFS, last: 1'b0});
			for (int i = 0; i < VERTEX_COUNT; i++) begin
				if (adj_rows[cur][i] && !seen_set[i] && tail < VERTEX_COUNT) begin
					seen_set[i] = 1'b1;
					fifo[tail] = i;
					tail++;
				end
			end
		end

		seen_set = '0;
		seen_set[start] = 1'b1;
		stk_v[0] = start;
		stk_next[0] = 0;
		depth = 1;
		run.push_back('{vertex: start[VIW-1:0], kind: KIND_DFS, last: 1'b0});
		while (depth > 0) begin
			cur = stk_v[depth-1];
			nxt = VERTEX_COUNT;
			for (int i = stk_next[depth-1]; i < VERTEX_COUNT; i++)
				if (nxt == VERTEX_COUNT && adj_rows[cur][i] && !seen_set[i]) nxt = i;
			if (nxt < VERTEX_COUNT && depth < VERTEX_COUNT) begin
				stk_next[depth-1] = nxt + 1;
				seen_set[nxt] = 1'b1;
				run.push_back('{vertex: nxt[VIW-1:0], kind: KIND_DFS, last: 1'b0});
				stk_v[depth] = nxt;
				stk_next[depth] = 0;
				depth++;
			end else begin
				depth--;
			end
		end

		for (int k = 0; k < run.size(); k++) begin
			vis = run[k];
			vis.last = (k == run.size() - 1);
			expected_visits.push_back(vis);
		end
	endfunction

	function automatic void report_field(string field, int want, int got);
		fail_count++;
		if (fail_count <= 30)
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
	endfunction

	function automatic graph_cmd_t make_cmd(logic act, int va, int vb);
		graph_cmd_t c;
		c.act = act;
		c.va = va[VIW-1:0];
		c.vb = vb[VIW-1:0];
		return c;
	endfunction

	initial begin
		for (int r = 0; r < VERTEX_COUNT; r++) adj_rows[r] = '0;

		// edgeless graph first, then a self loop becomes the start vertex
		pending_cmds.push_back(make_cmd(ACT_TRAVERSE, 7, 7));
		pending_cmds.push_back(make_cmd(ACT_TRAVERSE, 0, 0));
		pending_cmds.push_back(make_cmd(ACT_INSERT, 5, 5));
		pending_cmds.push_back(make_cmd(ACT_TRAVERSE, 2, 5));
		pending_cmds.push_back(make_cmd(ACT_INSERT, 5, 5));
		pending_cmds.push_back(make_cmd(ACT_INSERT, 7, 5));
		pending_cmds.push_back(make_cmd(ACT_INSERT, 6, 7));
		pending_cmds.push_back(make_cmd(ACT_INSERT, 7, 3));
		pending_cmds.push_back(make_cmd(ACT_TRAVERSE, 0, 7));
		// separate component at a lower index moves the start away
		pending_cmds.push_back(make_cmd(ACT_INSERT, 2, 4));
		pending_cmds.push_back(make_cmd(ACT_TRAVERSE, 7, 0));
		pending_cmds.push_back(make_cmd(ACT_INSERT, 4, 3));
		pending_cmds.push_back(make_cmd(ACT_INSERT, 1, 6));
		pending_cmds.push_back(make_cmd(ACT_TRAVERSE, 3, 3));
		pending_cmds.push_back(make_cmd(ACT_INSERT, 2, 2));
		pending_cmds.push_back(make_cmd(ACT_TRAVERSE, 1, 6));

		// keep vertex 0 out for a while so the start vertex and reach keep changing
		for (int n = 0; n < 155; n++) begin
			if ($urandom_range(0, 3) == 0)
				pending_cmds.push_back(make_cmd(ACT_TRAVERSE, $urandom_range(0, 7),
					$urandom_range(0, 7)));
			else if (n < 80)
				pending_cmds.push_back(make_cmd(ACT_INSERT, $urandom_range(1, 7),
					$urandom_range(1, 7)));
			else
				pending_cmds.push_back(make_cmd(ACT_INSERT, $urandom_range(0, 7),
					$urandom_range(0, 7)));
		end
		pending_cmds.push_back(make_cmd(ACT_TRAVERSE, 5, 2));

		repeat (10) @(negedge clk);
		arst_n = 1'b1;
	end

	// sender: bursts of words with random gaps, sometimes long gap-free runs
	always @(negedge clk) begin
		graph_cmd_t cmd;
		if (arst_n && (!s_tvalid || word_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (pending_cmds.size() > 0) begin
				cmd = pending_cmds.pop_front();
				s_tdata <= {2'b00, cmd.vb, cmd.va};
				s_tuser <= cmd.act;
				s_tvalid <= 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else if ($urandom_range(0, 4) == 0) begin
					burst_left = $urandom_range(10, 30);
					gap_left = 0;
				end else begin
					burst_left = $urandom_range(1, 6);
					gap_left = $urandom_range(1, 8);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: ready follows a 16-bit pattern, re-rolled each time pattern_age wraps to zero
	always @(negedge clk) begin
		if (arst_n) begin
			if (pattern_age == 0) begin
				case ($urandom_range(0, 3))
					0: begin
						ready_pattern = 16'hffff;
					end
					1: begin
						ready_pattern = 16'($urandom);
					end
					default: begin
						ready_pattern = 16'($urandom | $urandom);
					end
				endcase
			end
			m_tready <= ready_pattern[pattern_age % 16];
			pattern_age = (pattern_age + 1) % 64;
		end
	end

	// check outgoing words first, then fold an accepted input into the predictor
	always @(posedge clk) begin
		visit_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_visits.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected word, expected none, got vertex %0d kind %0d last %0d",
						$time, m_tdata, m_tuser, m_tlast);
				end else begin
					want = expected_visits.pop_front();
					if (m_tdata !== {5'b00000, want.vertex})
						report_field("vertex", want.vertex, m_tdata);
					if (m_tuser !== want.kind)
						report_field("order_kind", want.kind, m_tuser);
					if (m_tlast !== want.last)
						report_field("last", want.last, m_tlast);
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser == ACT_INSERT) begin
					if (int'(s_tdata[2:0]) < VERTEX_COUNT && int'(s_tdata[5:3]) < VERTEX_COUNT) begin
						adj_rows[s_tdata[2:0]][s_tdata[5:3]] = 1'b1;
						adj_rows[s_tdata[5:3]][s_tdata[2:0]] = 1'b1;
					end
				end else begin
					plan_traversal();
				end
			end
			word_taken <= s_tvalid && s_tready;
		end
	end

	initial begin
		wait (arst_n);
		while (pending_cmds.size() > 0 || s_tvalid) @(posedge clk);
		while (expected_visits.size() > 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("%0t: timeout, %0d words still expected", $time, expected_visits.size());
		$display("FAIL");
		$finish;
	end

endmodule
